### sv/sct_pkg.sv
`timescale 1ns / 1ps
package sct_pkg;

	localparam logic [9:0] M_INVITE = 10'd2;
	localparam logic [9:0] M_CANCEL = 10'd8;
	localparam logic [9:0] M_BYE    = 10'd9;
	localparam logic [9:0] M_ACK    = 10'd10;

	localparam logic [9:0] RC_100 = 10'd100;
	localparam logic [9:0] RC_200 = 10'd200;
	localparam logic [9:0] RC_300 = 10'd300;
	localparam logic [9:0] RC_400 = 10'd400;
	localparam logic [9:0] RC_700 = 10'd700;

	localparam logic [2:0] PH_NONE      = 3'd0;
	localparam logic [2:0] PH_SETUP     = 3'd1;
	localparam logic [2:0] PH_INCALL    = 3'd2;
	localparam logic [2:0] PH_CANCELLED = 3'd3;
	localparam logic [2:0] PH_REJECTED  = 3'd4;
	localparam logic [2:0] PH_BUSY      = 3'd5;
	localparam logic [2:0] PH_DIVERTED  = 3'd6;
	localparam logic [2:0] PH_COMPLETED = 3'd7;

	localparam logic [9:0] DC_NONE      = 10'd0;
	localparam logic [9:0] DC_BYE       = 10'd1;
	localparam logic [9:0] DC_CANCELLED = 10'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_APPLY,
		ST_EVAL,
		ST_SCAN,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		SK_ACK,
		SK_INV,
		SK_BYE
	} scan_kind_t;

	typedef struct packed {
		logic        new_call;
		logic [9:0]  msg_code;
		logic [31:0] seq_number;
		logic [31:0] src_ip;
		logic [15:0] src_port;
		logic [31:0] dst_ip;
		logic [15:0] dst_port;
	} msg_t;

	typedef struct packed {
		logic invite;
		logic bye;
		logic ack;
		logic cancel;
		logic busy;
		logic rej603;
		logic ok200;
		logic c487;
		logic rejc;
		logic divert;
		logic misc;
		logic m503;
		logic resp_rng;
	} cls_t;

	typedef struct packed {
		msg_t msg;
		cls_t cls;
	} q_ent_t;

	function automatic cls_t classify(logic [9:0] c);
		cls_t r;
		r.invite   = (c == M_INVITE);
		r.bye      = (c == M_BYE);
		r.ack      = (c == M_ACK);
		r.cancel   = (c == M_CANCEL);
		r.busy     = (c == 10'd480) || (c == 10'd486) || (c == 10'd600);
		r.rej603   = (c == 10'd603);
		r.ok200    = (c == RC_200);
		r.c487     = (c == 10'd487);
		r.rejc     = (c > RC_400) && (c != 10'd407) && (c != 10'd401);
		r.divert   = (c == 10'd181) || (c == 10'd302) || (c == 10'd301);
		r.misc     = (c == 10'd404) || (c == 10'd503) || (c == 10'd488);
		r.m503     = (c == 10'd503);
		r.resp_rng = (c >= RC_200) && (c < RC_700);
		return r;
	endfunction

endpackage

### sv/sct_if.sv
`timescale 1ns / 1ps
interface sct_msg_if;
	logic        valid;
	logic        ready;
	logic        new_call;
	logic [9:0]  msg_code;
	logic [31:0] seq_number;
	logic [31:0] src_ip;
	logic [15:0] src_port;
	logic [31:0] dst_ip;
	logic [15:0] dst_port;

	modport source(output valid, new_call, msg_code, seq_number, src_ip, src_port,
		dst_ip, dst_port, input ready);
	modport sink(input valid, new_call, msg_code, seq_number, src_ip, src_port,
		dst_ip, dst_port, output ready);
endinterface

interface sct_res_if;
	logic        valid;
	logic        ready;
	logic [2:0]  call_state;
	logic [9:0]  disc_cause;
	logic [31:0] disconnect_ip;
	logic [15:0] disconnect_port;
	logic        disconnect_valid;
	logic        established_mark;
	logic        ended_mark;
	logic        history_full;

	modport source(output valid, call_state, disc_cause, disconnect_ip,
		disconnect_port, disconnect_valid, established_mark, ended_mark,
		history_full, input ready);
	modport sink(input valid, call_state, disc_cause, disconnect_ip,
		disconnect_port, disconnect_valid, established_mark, ended_mark,
		history_full, output ready);
endinterface

### sv/sip_call_state_tracker.sv
`timescale 1ns / 1ps
// SIP call state tracker.
// msg: one SIP message per request (method or response code, CSeq, addresses).
// res: one result per message: call state, disconnect cause and ender, and the
//      established / ended / history-full marks for that message.
// A front queue of two entries decodes the message code and takes requests
// while the back end works; the back end handles one message at a time.
// Messages that search the history (ACK in setup, 200 for another CSeq, a
// response in call) hold the back end until the search of the stored entries
// is done.
// The history is one single-port-write, registered-read memory; the search
// reads one entry per cycle, newest first.
// Reset clears the call state and history count; no clearing pass is needed.
// A stalled result is held in the output register; the queue keeps taking
// requests until it holds two, then msg.ready drops.
module sip_call_state_tracker import sct_pkg::*; #(
	parameter int HISTORY_DEPTH = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	sct_msg_if.sink   msg,
	sct_res_if.source res
);

	logic   pop_valid;
	logic   pop_ready;
	q_ent_t pop_data;

	sct_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg       (msg),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data)
	);

	sct_back #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.res       (res)
	);

endmodule

### sv/sct_front.sv
`timescale 1ns / 1ps
module sct_front import sct_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	sct_msg_if.sink     msg,
	output logic        pop_valid,
	input  logic        pop_ready,
	output q_ent_t      pop_data
);

	q_ent_t     ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;
	msg_t       m;

	always_comb begin
		m.new_call   = msg.new_call;
		m.msg_code   = msg.msg_code;
		m.seq_number = msg.seq_number;
		m.src_ip     = msg.src_ip;
		m.src_port   = msg.src_port;
		m.dst_ip     = msg.dst_ip;
		m.dst_port   = msg.dst_port;
	end

	assign msg.ready = (cnt_q != 2'd2);
	assign push      = msg.valid && msg.ready;
	assign pop_valid = (cnt_q != 2'd0);
	assign pop       = pop_valid && pop_ready;
	assign pop_data  = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= '{msg: m, cls: classify(m.msg_code)};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("queue count out of range");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd1) |-> (wr_ptr_q != rd_ptr_q)) else $error("queue pointer mismatch");
	a_full_eq: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q)) else $error("queue full pointer mismatch");

endmodule

### sv/sct_back.sv
`timescale 1ns / 1ps
module sct_back import sct_pkg::*; #(
	parameter int HISTORY_DEPTH = 64
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    pop_valid,
	output logic    pop_ready,
	input  q_ent_t  pop_data,
	sct_res_if.source res
);

	localparam int AW = $clog2(HISTORY_DEPTH);
	localparam int CW = $clog2(HISTORY_DEPTH + 1);

	state_t      state_q, state_n;
	q_ent_t      it_q;
	scan_kind_t  kind_q, kind_n;

	logic [2:0]  phase_q, phase_n;
	logic [31:0] sseq_q, sseq_n;
	logic        fii_q, fii_n;
	logic [9:0]  code_q, code_n;
	logic [31:0] eip_q, eip_n;
	logic [15:0] eport_q, eport_n;
	logic        eknown_q, eknown_n;
	logic [CW-1:0] cnt_q, cnt_n;
	logic        est_q, est_n;
	logic        ended_q, ended_n;
	logic        full_q, full_n;
	logic        seen200_q, seen200_n;
	logic [AW-1:0] idx_q, idx_n;
	logic [CW-1:0] left_q, left_n;

	logic [41:0] mem [HISTORY_DEPTH];
	logic        wr_en;
	logic [AW-1:0] wr_addr;
	logic        rd_en;
	logic [41:0] rd_s1;
	logic        rv_s1;

	logic        ovalid_q;
	logic        load_out;
	logic [CW-1:0] cnt_eff;
	logic [9:0]  e_code;
	logic [31:0] e_seq;
	msg_t        m;
	cls_t        c;

	assign m = it_q.msg;
	assign c = it_q.cls;
	assign e_code = rd_s1[41:32];
	assign e_seq  = rd_s1[31:0];
	assign pop_ready = (state_q == ST_IDLE);
	assign cnt_eff = m.new_call ? '0 : cnt_q;

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= {m.msg_code, m.seq_number};
		if (rd_en) rd_s1 <= mem[idx_q];
	end

	always_comb begin
		state_n   = state_q;
		kind_n    = kind_q;
		phase_n   = phase_q;
		sseq_n    = sseq_q;
		fii_n     = fii_q;
		code_n    = code_q;
		eip_n     = eip_q;
		eport_n   = eport_q;
		eknown_n  = eknown_q;
		cnt_n     = cnt_q;
		est_n     = est_q;
		ended_n   = ended_q;
		full_n    = full_q;
		seen200_n = seen200_q;
		idx_n     = idx_q;
		left_n    = left_q;
		wr_en     = 1'b0;
		wr_addr   = cnt_eff[AW-1:0];
		rd_en     = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (pop_valid) state_n = ST_APPLY;
			end
			ST_APPLY: begin
				est_n   = 1'b0;
				ended_n = 1'b0;
				full_n  = 1'b0;
				if (m.new_call) begin
					phase_n  = PH_NONE;
					sseq_n   = '0;
					fii_n    = 1'b0;
					code_n   = DC_NONE;
					eip_n    = '0;
					eport_n  = '0;
					eknown_n = 1'b0;
				end
				if (cnt_eff < CW'(HISTORY_DEPTH)) begin
					if (cnt_eff == '0) fii_n = c.invite;
					wr_en = 1'b1;
					cnt_n = cnt_eff + 1'b1;
				end else begin
					cnt_n  = cnt_eff;
					full_n = 1'b1;
				end
				state_n = ST_EVAL;
			end
			ST_EVAL: begin
				state_n   = ST_OUT;
				idx_n     = AW'(cnt_q - 1'b1);
				left_n    = cnt_q;
				seen200_n = 1'b0;
				if (fii_q) begin
					if (c.bye) begin
						phase_n = PH_COMPLETED;
						ended_n = 1'b1;
						if (!eknown_q) begin
							eip_n = m.src_ip; eport_n = m.src_port; eknown_n = 1'b1;
						end
						if (code_q == DC_NONE) code_n = DC_BYE;
					end else if (phase_q == PH_SETUP) begin
						if (c.ack) begin
							if (m.seq_number == sseq_q) begin
								kind_n  = SK_ACK;
								state_n = ST_SCAN;
							end
						end else if (c.cancel || c.busy || c.rej603 ||
								(c.c487 && m.seq_number == sseq_q) ||
								(c.misc && !(c.rejc && m.seq_number == sseq_q) &&
								!c.divert)) begin
							// all of these record the source as the ender
							if (!eknown_q) begin
								eip_n = m.src_ip; eport_n = m.src_port; eknown_n = 1'b1;
							end
							if (code_q == DC_NONE)
								code_n = c.cancel ? DC_CANCELLED : m.msg_code;
							if (c.cancel || c.c487) phase_n = PH_CANCELLED;
							else if (c.busy || c.m503) phase_n = PH_BUSY;
							else phase_n = PH_REJECTED;
						end else if (c.ok200) begin
							if (m.seq_number == sseq_q) begin
								phase_n = PH_INCALL;
							end else begin
								kind_n  = SK_INV;
								state_n = ST_SCAN;
							end
						end else if (c.rejc && m.seq_number == sseq_q) begin
							phase_n = PH_REJECTED;
							if (code_q == DC_NONE) begin
								code_n = m.msg_code;
								if (!eknown_q) begin
									eip_n = m.dst_ip; eport_n = m.dst_port; eknown_n = 1'b1;
								end
							end
						end else if (c.divert) begin
							phase_n = PH_DIVERTED;
						end
					end else if (phase_q == PH_CANCELLED && c.c487) begin
						if (code_q == DC_CANCELLED) code_n = m.msg_code;
					end else if (phase_q == PH_INCALL) begin
						if (c.rej603) begin
							phase_n = PH_REJECTED;
							if (code_q == DC_NONE) code_n = m.msg_code;
							if (!eknown_q) begin
								eip_n = m.src_ip; eport_n = m.src_port; eknown_n = 1'b1;
							end
						end else if (c.resp_rng && m.seq_number != '0) begin
							kind_n  = SK_BYE;
							state_n = ST_SCAN;
						end
					end else if (c.invite) begin
						sseq_n  = m.seq_number;
						phase_n = PH_SETUP;
					end
				end
			end
			ST_SCAN: begin
				// newest entry first; read data arrives in the cycle after the address
				if (left_q != '0) begin
					rd_en  = 1'b1;
					idx_n  = idx_q - 1'b1;
					left_n = left_q - 1'b1;
				end
				if (rv_s1) begin
					unique case (kind_q)
						SK_ACK: begin
							if (e_seq == m.seq_number && e_code >= RC_100 && e_code < RC_700) begin
								state_n = ST_OUT;
								if (e_code >= RC_200 && e_code < RC_300) begin
									phase_n = PH_INCALL;
									est_n   = 1'b1;
								end
							end else if (e_code == RC_200) begin
								seen200_n = 1'b1;
							end
						end
						SK_INV: begin
							if (e_code == M_INVITE && e_seq == m.seq_number) begin
								state_n = ST_OUT;
								phase_n = PH_INCALL;
								sseq_n  = m.seq_number;
							end
						end
						SK_BYE: begin
							if (e_code == M_BYE && e_seq == m.seq_number) begin
								state_n = ST_OUT;
								phase_n = PH_COMPLETED;
								if (code_q == DC_NONE || code_q == DC_BYE) code_n = m.msg_code;
								if (!eknown_q) begin
									eip_n = m.src_ip; eport_n = m.src_port; eknown_n = 1'b1;
								end
							end
						end
						default: state_n = ST_OUT;
					endcase
				end else if (left_q == '0) begin
					state_n = ST_OUT;
					if (kind_q == SK_ACK && seen200_q) begin
						phase_n = PH_INCALL;
						est_n   = 1'b1;
					end
				end
			end
			ST_OUT: begin
				if (!ovalid_q || res.ready) begin
					load_out = 1'b1;
					state_n  = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q    <= SK_ACK;
			phase_q   <= PH_NONE;
			sseq_q    <= '0;
			fii_q     <= 1'b0;
			code_q    <= DC_NONE;
			eip_q     <= '0;
			eport_q   <= '0;
			eknown_q  <= 1'b0;
			cnt_q     <= '0;
			est_q     <= 1'b0;
			ended_q   <= 1'b0;
			full_q    <= 1'b0;
			seen200_q <= 1'b0;
			idx_q     <= '0;
			left_q    <= '0;
			rv_s1     <= 1'b0;
			ovalid_q  <= 1'b0;
		end else begin
			kind_q    <= kind_n;
			phase_q   <= phase_n;
			sseq_q    <= sseq_n;
			fii_q     <= fii_n;
			code_q    <= code_n;
			eip_q     <= eip_n;
			eport_q   <= eport_n;
			eknown_q  <= eknown_n;
			cnt_q     <= cnt_n;
			est_q     <= est_n;
			ended_q   <= ended_n;
			full_q    <= full_n;
			seen200_q <= seen200_n;
			idx_q     <= idx_n;
			left_q    <= left_n;
			rv_s1     <= rd_en;
			if (load_out) ovalid_q <= 1'b1;
			else if (res.ready) ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop_valid && pop_ready) it_q <= pop_data;
		if (load_out) begin
			res.call_state       <= phase_q;
			res.disc_cause       <= code_q;
			res.disconnect_ip    <= eip_q;
			res.disconnect_port  <= eport_q;
			res.disconnect_valid <= eknown_q;
			res.established_mark <= est_q;
			res.ended_mark       <= ended_q;
			res.history_full     <= full_q;
		end
	end

	assign res.valid = ovalid_q;

	a_scan_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (cnt_q != '0)) else $error("scan over empty history");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(HISTORY_DEPTH)) else $error("history count overflow");
	a_est_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && est_q) |-> (phase_q == PH_INCALL))
		else $error("established without in-call state");
	a_end_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && ended_q) |-> (phase_q == PH_COMPLETED))
		else $error("ended without completed state");
	a_ender_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!eknown_q |-> (eip_q == '0 && eport_q == '0)) else $error("ender set while unknown");

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
module tb;
	import sct_pkg::*;

	localparam int DEPTH = 64;
	localparam int N_RANDOM = 1000;

	typedef struct packed {
		logic [2:0]  call_state;
		logic [9:0]  disc_cause;
		logic [31:0] disconnect_ip;
		logic [15:0] disconnect_port;
		logic        disconnect_valid;
		logic        established_mark;
		logic        ended_mark;
		logic        history_full;
	} verdict_t;

	logic clk;
	logic arst_n;

	sct_msg_if msg();
	sct_res_if res();

	sip_call_state_tracker #(.HISTORY_DEPTH(DEPTH)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.msg(msg),
		.res(res)
	);

	// tracker model state
	logic [2:0]  phase;
	logic [31:0] setup_cseq;
	logic        opened_by_invite;
	logic [9:0]  end_code;
	logic [31:0] ender_addr;
	logic [15:0] ender_prt;
	logic        ender_set;
	logic [9:0]  log_code [DEPTH];
	logic [31:0] log_cseq [DEPTH];
	int          log_len;

	msg_t     pending_msgs[$];
	verdict_t expected_verdicts[$];
	int       n_errors;
	int       n_checked;
	int       n_established;
	int       n_ended;
	int       n_full;
	int       n_calls;
	int       hold_cycles;
	bit       long_hold;

	initial begin
		clk = 1'b0;
	end
	always #5 clk = ~clk;

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		n_errors++;
		$display("mismatch #%0d %s: got %0d want %0d", n_checked, what, got, want);
	endtask

	task automatic note_ender(input logic [31:0] ip, input logic [15:0] port);
		if (!ender_set) begin
			ender_addr = ip;
			ender_prt = port;
			ender_set = 1'b1;
		end
	endtask

	task automatic note_code(input logic [9:0] c);
		if (end_code == DC_NONE)
			end_code = c;
	endtask

	task automatic forget_call();
		phase = PH_NONE;
		setup_cseq = '0;
		opened_by_invite = 1'b0;
		end_code = DC_NONE;
		ender_addr = '0;
		ender_prt = '0;
		ender_set = 1'b0;
		log_len = 0;
	endtask

	function automatic bit is_busy(input logic [9:0] c);
		return c == 10'd480 || c == 10'd486 || c == 10'd600;
	endfunction

	task automatic track_message(input msg_t m);
		verdict_t v;
		logic [9:0] c;
		bit hit;
		logic [9:0] rc;
		v = '0;
		c = m.msg_code;
		if (m.new_call)
			forget_call();
		if (log_len < DEPTH) begin
			if (log_len == 0)
				opened_by_invite = (c == M_INVITE);
			log_code[log_len] = c;
			log_cseq[log_len] = m.seq_number;
			log_len++;
		end else begin
			v.history_full = 1'b1;
		end
		if (opened_by_invite) begin
			if (c == M_BYE) begin
				phase = PH_COMPLETED;
				v.ended_mark = 1'b1;
				note_ender(m.src_ip, m.src_port);
				note_code(DC_BYE);
			end else if (phase == PH_SETUP) begin
				if (c == M_ACK) begin
					if (m.seq_number == setup_cseq) begin
						hit = 0;
						rc = '0;
						for (int i = log_len - 1; i >= 0; i--) begin
							if (log_cseq[i] == m.seq_number && log_code[i] >= RC_100
									&& log_code[i] < RC_700) begin
								hit = 1;
								rc = log_code[i];
								break;
							end
						end
						if (hit) begin
							if (rc >= RC_200 && rc < RC_300) begin
								phase = PH_INCALL;
								v.established_mark = 1'b1;
							end
						end else begin
							for (int i = log_len - 1; i >= 0; i--) begin
								if (log_code[i] == RC_200) begin
									phase = PH_INCALL;
									v.established_mark = 1'b1;
									break;
								end
							end
						end
					end
				end else if (c == M_CANCEL) begin
					phase = PH_CANCELLED;
					note_ender(m.src_ip, m.src_port);
					note_code(DC_CANCELLED);
				end else if (is_busy(c)) begin
					phase = PH_BUSY;
					note_code(c);
					note_ender(m.src_ip, m.src_port);
				end else if (c == 10'd603) begin
					phase = PH_REJECTED;
					note_code(c);
					note_ender(m.src_ip, m.src_port);
				end else if (c == RC_200) begin
					if (m.seq_number == setup_cseq) begin
						phase = PH_INCALL;
					end else begin
						for (int i = 0; i < log_len; i++) begin
							if (log_code[i] == M_INVITE && log_cseq[i] == m.seq_number) begin
								phase = PH_INCALL;
								setup_cseq = m.seq_number;
								break;
							end
						end
					end
				end else if (c == 10'd487 && setup_cseq == m.seq_number) begin
					phase = PH_CANCELLED;
					note_ender(m.src_ip, m.src_port);
					note_code(c);
				end else if (c > RC_400 && c != 10'd407 && c != 10'd401
						&& setup_cseq == m.seq_number) begin
					phase = PH_REJECTED;
					if (end_code == DC_NONE) begin
						end_code = c;
						note_ender(m.dst_ip, m.dst_port);
					end
				end else if (c == 10'd181 || c == 10'd302 || c == 10'd301) begin
					phase = PH_DIVERTED;
				end else if (c == 10'd404 || c == 10'd503 || c == 10'd488) begin
					note_code(c);
					note_ender(m.src_ip, m.src_port);
					phase = (c == 10'd503) ? PH_BUSY : PH_REJECTED;
				end
			end else if (phase == PH_CANCELLED && c == 10'd487) begin
				if (end_code == DC_CANCELLED)
					end_code = c;
			end else if (phase == PH_INCALL) begin
				if (c == 10'd603) begin
					phase = PH_REJECTED;
					note_code(c);
					note_ender(m.src_ip, m.src_port);
				end else if (c >= RC_200 && c < RC_700 && m.seq_number > 0) begin
					for (int i = 0; i < log_len; i++) begin
						if (log_code[i] == M_BYE && log_cseq[i] == m.seq_number) begin
							phase = PH_COMPLETED;
							if (end_code == DC_BYE)
								end_code = DC_NONE;
							note_code(c);
							note_ender(m.src_ip, m.src_port);
							break;
						end
					end
				end
			end else if (c == M_INVITE) begin
				setup_cseq = m.seq_number;
				phase = PH_SETUP;
			end
		end
		v.call_state = phase;
		v.disc_cause = end_code;
		v.disconnect_ip = ender_addr;
		v.disconnect_port = ender_prt;
		v.disconnect_valid = ender_set;
		expected_verdicts.push_back(v);
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// driver
	int   drv_gap;
	msg_t cur_msg;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msg.valid <= 1'b0;
			drv_gap <= 0;
		end else begin
			if (msg.valid && msg.ready) begin
				track_message(cur_msg);
				void'(pending_msgs.pop_front());
			end
			if (msg.valid && !msg.ready) begin
				// keep offering the same request
			end else if (drv_gap > 0) begin
				msg.valid <= 1'b0;
				drv_gap <= drv_gap - 1;
			end else if (pending_msgs.size() > 0) begin
				cur_msg = pending_msgs[0];
				msg.valid <= 1'b1;
				msg.new_call <= cur_msg.new_call;
				msg.msg_code <= cur_msg.msg_code;
				msg.seq_number <= cur_msg.seq_number;
				msg.src_ip <= cur_msg.src_ip;
				msg.src_port <= cur_msg.src_port;
				msg.dst_ip <= cur_msg.dst_ip;
				msg.dst_port <= cur_msg.dst_port;
				drv_gap <= pick_gap();
			end else begin
				msg.valid <= 1'b0;
			end
		end
	end

	// monitor
	verdict_t want;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
			hold_cycles <= 0;
		end else begin
			if (res.valid && res.ready) begin
				n_checked++;
				if (expected_verdicts.size() == 0) begin
					report("unexpected result", 0, 0);
				end else begin
					want = expected_verdicts.pop_front();
					if (res.call_state !== want.call_state)
						report("call_state", res.call_state, want.call_state);
					if (res.disc_cause !== want.disc_cause)
						report("disc_cause", res.disc_cause, want.disc_cause);
					if (res.disconnect_ip !== want.disconnect_ip)
						report("disconnect_ip", res.disconnect_ip, want.disconnect_ip);
					if (res.disconnect_port !== want.disconnect_port)
						report("disconnect_port", res.disconnect_port, want.disconnect_port);
					if (res.disconnect_valid !== want.disconnect_valid)
						report("disconnect_valid", res.disconnect_valid, want.disconnect_valid);
					if (res.established_mark !== want.established_mark)
						report("established_mark", res.established_mark, want.established_mark);
					if (res.ended_mark !== want.ended_mark)
						report("ended_mark", res.ended_mark, want.ended_mark);
					if (res.history_full !== want.history_full)
						report("history_full", res.history_full, want.history_full);
					n_established += want.established_mark;
					n_ended += want.ended_mark;
					n_full += want.history_full;
				end
			end
			if (long_hold) begin
				hold_cycles <= 400;
				res.ready <= 1'b0;
			end else if (hold_cycles > 0) begin
				hold_cycles <= hold_cycles - 1;
				res.ready <= 1'b0;
			end else begin
				hold_cycles <= pick_gap();
				res.ready <= 1'b1;
			end
		end
	end

	function automatic msg_t make_msg(input bit nc, input logic [9:0] c, input logic [31:0] s);
		msg_t m;
		m.new_call = nc;
		m.msg_code = c;
		m.seq_number = s;
		m.src_ip = $urandom;
		m.src_port = 16'($urandom);
		m.dst_ip = $urandom;
		m.dst_port = 16'($urandom);
		return m;
	endfunction

	function automatic logic [9:0] any_code();
		logic [9:0] pool [20] = '{M_INVITE, M_CANCEL, M_BYE, M_ACK, 10'd200, 10'd480,
			10'd486, 10'd600, 10'd603, 10'd487, 10'd407, 10'd401, 10'd181, 10'd302,
			10'd301, 10'd404, 10'd503, 10'd488, 10'd100, 10'd180};
		if ($urandom_range(0, 9) == 0)
			return 10'($urandom_range(0, 1023));
		return pool[$urandom_range(0, 19)];
	endfunction

	// one call: usually INVITE first, then mostly plausible traffic around a few CSeq values
	task automatic queue_call(input int len);
		logic [31:0] base;
		logic [31:0] s;
		base = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 4);
		n_calls++;
		pending_msgs.push_back(make_msg(1'b1,
			($urandom_range(0, 9) == 0) ? any_code() : M_INVITE, base));
		for (int i = 1; i < len; i++) begin
			s = base + $urandom_range(0, 2);
			if ($urandom_range(0, 19) == 0)
				s = $urandom;
			pending_msgs.push_back(make_msg($urandom_range(0, 49) == 0, any_code(), s));
		end
	endtask

	task automatic wait_drained();
		while (pending_msgs.size() != 0 || msg.valid || expected_verdicts.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		msg_t m;
		int sent;
		n_errors = 0;
		n_checked = 0;
		n_calls = 0;
		long_hold = 0;
		forget_call();
		msg.valid = 1'b0;
		msg.new_call = 1'b0;
		msg.msg_code = '0;
		msg.seq_number = '0;
		msg.src_ip = '0;
		msg.src_port = '0;
		msg.dst_ip = '0;
		msg.dst_port = '0;
		res.ready = 1'b0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed: basic call, established then ended by BYE and its 200
		pending_msgs.push_back(make_msg(1'b1, M_INVITE, 32'd1));
		pending_msgs.push_back(make_msg(1'b0, 10'd180, 32'd1));
		pending_msgs.push_back(make_msg(1'b0, 10'd200, 32'd1));
		pending_msgs.push_back(make_msg(1'b0, M_ACK, 32'd1));
		pending_msgs.push_back(make_msg(1'b0, M_BYE, 32'd2));
		pending_msgs.push_back(make_msg(1'b0, 10'd200, 32'd2));
		// first message not an INVITE: BYE ignored
		pending_msgs.push_back(make_msg(1'b1, 10'd200, 32'hFFFF_FFFF));
		pending_msgs.push_back(make_msg(1'b0, M_BYE, 32'hFFFF_FFFF));
		// cancel then 487
		pending_msgs.push_back(make_msg(1'b1, M_INVITE, 32'hFFFF_FFFF));
		pending_msgs.push_back(make_msg(1'b0, M_CANCEL, 32'hFFFF_FFFF));
		pending_msgs.push_back(make_msg(1'b0, 10'd487, 32'hFFFF_FFFF));
		// rejected with code above 699 and with 503, then diverted and declined calls
		pending_msgs.push_back(make_msg(1'b1, M_INVITE, 32'd0));
		pending_msgs.push_back(make_msg(1'b0, 10'd1023, 32'd0));
		pending_msgs.push_back(make_msg(1'b1, M_INVITE, 32'd5));
		m = make_msg(1'b0, 10'd503, 32'd5);
		m.src_ip = '1; m.src_port = '1; m.dst_ip = '1; m.dst_port = '1;
		pending_msgs.push_back(m);
		pending_msgs.push_back(make_msg(1'b1, M_INVITE, 32'd7));
		pending_msgs.push_back(make_msg(1'b0, 10'd302, 32'd7));
		pending_msgs.push_back(make_msg(1'b1, M_INVITE, 32'd7));
		pending_msgs.push_back(make_msg(1'b0, 10'd603, 32'd7));
		wait_drained();

		// fill the history past its end while results are held back
		long_hold = 1;
		queue_call(DEPTH + 4);
		pending_msgs.push_back(make_msg(1'b0, M_BYE, 32'd9));
		repeat (300) @(posedge clk);
		long_hold = 0;
		wait_drained();

		sent = 0;
		while (sent < N_RANDOM) begin
			int len;
			if ($urandom_range(0, 9) == 0) begin
				pending_msgs.push_back(make_msg(1'($urandom_range(0, 1)),
					10'($urandom_range(0, 1023)), $urandom));
				len = 1;
			end else begin
				len = ($urandom_range(0, 29) == 0) ? $urandom_range(DEPTH - 2, DEPTH + 6)
					: $urandom_range(2, 12);
				queue_call(len);
			end
			sent += len;
			while (pending_msgs.size() > 16)
				@(posedge clk);
		end
		wait_drained();
		repeat (DEPTH + 20) @(posedge clk);
		$display("checked %0d results over %0d calls: %0d established, %0d ended, %0d history full",
			n_checked, n_calls, n_established, n_ended, n_full);
		if (n_errors == 0 && expected_verdicts.size() == 0)
			$display("[sip_call_state_tracker] OK");
		else
			$display("[sip_call_state_tracker] ERROR");
		$finish;
	end

	initial begin
		#20ms;
		$display("[sip_call_state_tracker] ERROR");
		$finish;
	end
endmodule
